FILE: rtl/tps_pkg.sv
`timescale 1ns / 1ps

package tps_pkg;

   localparam int WordWidth   = 32;
   localparam int IdxWidth    = 20;
   localparam int CountWidth  = 32;
   localparam int SumWidth    = 11;
   localparam int PopWidth    = 6;
   localparam int ThreshWidth = 16;
   localparam int LhsWidth    = SumWidth + 1 + 8;
   localparam int RhsWidth    = ThreshWidth + SumWidth;

   localparam logic [ThreshWidth-1:0] ThreshReset = 16'd768;
   localparam logic [SumWidth-1:0]    SumMax      = 11'd2047;

   // popcounts of one word pair
   typedef struct packed {
      logic [PopWidth-1:0] ref_pop;
      logic [PopWidth-1:0] cmp_pop;
      logic [PopWidth-1:0] and_pop;
      logic                last_word;
      logic [IdxWidth-1:0] ref_index;
      logic [IdxWidth-1:0] cmp_index;
   } word_weight_type;

   // weights of one closed fingerprint pair
   typedef struct packed {
      logic [SumWidth-1:0] ref_sum;
      logic [SumWidth-1:0] cmp_sum;
      logic [SumWidth-1:0] and_sum;
      logic [IdxWidth-1:0] ref_index;
      logic [IdxWidth-1:0] cmp_index;
   } pair_total_type;

   function automatic logic [PopWidth-1:0] popcount_word(input logic [WordWidth-1:0] w);
      logic [PopWidth-1:0] c;
      c = '0;
      for (int i = 0; i < WordWidth; i++) begin
         c = c + PopWidth'(w[i]);
      end
      return c;
   endfunction

   function automatic logic [SumWidth-1:0] sat_add(input logic [SumWidth-1:0] sum,
                                                   input logic [PopWidth-1:0] pop);
      logic [SumWidth:0] s;
      s = {1'b0, sum} + (SumWidth+1)'(pop);
      return s[SumWidth] ? SumMax : s[SumWidth-1:0];
   endfunction

endpackage

FILE: rtl/tps_req_if.sv
`timescale 1ns / 1ps

interface tps_req_if;
   import tps_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [WordWidth-1:0] ref_word;
   logic [WordWidth-1:0] cmp_word;
   logic                 last_word;
   logic [IdxWidth-1:0]  ref_index;
   logic [IdxWidth-1:0]  cmp_index;

   modport source (output valid, ref_word, cmp_word, last_word, ref_index, cmp_index,
                   input ready);
   modport sink (input valid, ref_word, cmp_word, last_word, ref_index, cmp_index,
                 output ready);
endinterface

FILE: rtl/tps_rsp_if.sv
`timescale 1ns / 1ps

interface tps_rsp_if;
   import tps_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [IdxWidth-1:0]   match_ref_index;
   logic [IdxWidth-1:0]   match_cmp_index;
   logic [CountWidth-1:0] match_count;

   modport source (output valid, match_ref_index, match_cmp_index, match_count,
                   input ready);
   modport sink (input valid, match_ref_index, match_cmp_index, match_count,
                 output ready);
endinterface

FILE: rtl/tps_weigh.sv
`timescale 1ns / 1ps

module tps_weigh (
   input  logic                     clock,
   input  logic                     reset,
   tps_req_if.sink                  req_ch,
   input  logic                     down_ready,
   output logic                     weight_valid,
   output tps_pkg::word_weight_type weight
);
   import tps_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic [WordWidth-1:0] in_ref_word_ff;
   logic [WordWidth-1:0] in_cmp_word_ff;
   logic                 in_last_ff;
   logic [IdxWidth-1:0]  in_ref_index_ff;
   logic [IdxWidth-1:0]  in_cmp_index_ff;
   logic                 pop_valid_ff, pop_valid_in;
   word_weight_type      weight_ff, weight_in;
   logic                 pop_ready;
   logic                 in_ready;

   assign pop_ready    = !pop_valid_ff || down_ready;
   assign in_ready     = !in_valid_ff || pop_ready;
   assign req_ch.ready = in_ready;

   assign in_valid_in  = in_ready ? req_ch.valid : in_valid_ff;
   assign pop_valid_in = pop_ready ? in_valid_ff : pop_valid_ff;

   always_comb begin
      weight_in.ref_pop   = popcount_word(in_ref_word_ff);
      weight_in.cmp_pop   = popcount_word(in_cmp_word_ff);
      weight_in.and_pop   = popcount_word(in_ref_word_ff & in_cmp_word_ff);
      weight_in.last_word = in_last_ff;
      weight_in.ref_index = in_ref_index_ff;
      weight_in.cmp_index = in_cmp_index_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         pop_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         pop_valid_ff <= pop_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_ch.valid) begin
         in_ref_word_ff  <= req_ch.ref_word;
         in_cmp_word_ff  <= req_ch.cmp_word;
         in_last_ff      <= req_ch.last_word;
         in_ref_index_ff <= req_ch.ref_index;
         in_cmp_index_ff <= req_ch.cmp_index;
      end
      if (pop_ready && in_valid_ff) begin
         weight_ff <= weight_in;
      end
   end

   assign weight_valid = pop_valid_ff;
   assign weight       = weight_ff;

endmodule

FILE: rtl/tps_accum.sv
`timescale 1ns / 1ps

module tps_accum #(
   parameter int FP_WORDS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     weight_valid,
   input  tps_pkg::word_weight_type weight,
   output logic                     take_ready,
   input  logic                     down_ready,
   output logic                     pair_valid,
   output tps_pkg::pair_total_type  pair
);
   import tps_pkg::*;

   localparam int PosWidth = (FP_WORDS > 1) ? $clog2(FP_WORDS) : 1;

   logic [SumWidth-1:0] ref_sum_ff, ref_sum_in;
   logic [SumWidth-1:0] cmp_sum_ff, cmp_sum_in;
   logic [SumWidth-1:0] and_sum_ff, and_sum_in;
   logic [PosWidth-1:0] pos_ff, pos_in;
   logic                pair_valid_ff, pair_valid_in;
   pair_total_type      pair_ff, pair_in;
   logic [PosWidth:0]   pos_inc;
   logic [SumWidth-1:0] ref_new, cmp_new, and_new;
   logic                take;
   logic                close;

   assign take_ready = !pair_valid_ff || down_ready;
   assign take       = weight_valid && take_ready;

   assign ref_new = sat_add(ref_sum_ff, weight.ref_pop);
   assign cmp_new = sat_add(cmp_sum_ff, weight.cmp_pop);
   assign and_new = sat_add(and_sum_ff, weight.and_pop);
   assign pos_inc = {1'b0, pos_ff} + (PosWidth+1)'(1);
   assign close   = weight.last_word || (pos_inc >= (PosWidth+1)'(FP_WORDS));

   always_comb begin
      ref_sum_in        = ref_sum_ff;
      cmp_sum_in        = cmp_sum_ff;
      and_sum_in        = and_sum_ff;
      pos_in            = pos_ff;
      pair_valid_in     = take_ready ? 1'b0 : pair_valid_ff;
      pair_in.ref_sum   = ref_new;
      pair_in.cmp_sum   = cmp_new;
      pair_in.and_sum   = and_new;
      pair_in.ref_index = weight.ref_index;
      pair_in.cmp_index = weight.cmp_index;
      if (take) begin
         if (close) begin
            ref_sum_in    = '0;
            cmp_sum_in    = '0;
            and_sum_in    = '0;
            pos_in        = '0;
            pair_valid_in = 1'b1;
         end else begin
            ref_sum_in = ref_new;
            cmp_sum_in = cmp_new;
            and_sum_in = and_new;
            pos_in     = pos_inc[PosWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_sum_ff    <= '0;
         cmp_sum_ff    <= '0;
         and_sum_ff    <= '0;
         pos_ff        <= '0;
         pair_valid_ff <= 1'b0;
      end else begin
         ref_sum_ff    <= ref_sum_in;
         cmp_sum_ff    <= cmp_sum_in;
         and_sum_ff    <= and_sum_in;
         pos_ff        <= pos_in;
         pair_valid_ff <= pair_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && close) begin
         pair_ff <= pair_in;
      end
   end

   assign pair_valid = pair_valid_ff;
   assign pair       = pair_ff;

endmodule

FILE: rtl/tps_judge.sv
`timescale 1ns / 1ps

module tps_judge (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [tps_pkg::ThreshWidth-1:0] threshold,
   input  logic                            pair_valid,
   input  tps_pkg::pair_total_type         pair,
   output logic                            take_ready,
   tps_rsp_if.source                       rsp_ch
);
   import tps_pkg::*;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IdxWidth-1:0]   ref_index_ff;
   logic [IdxWidth-1:0]   cmp_index_ff;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [SumWidth:0]     weight_sum;
   logic [LhsWidth-1:0]   lhs;
   logic [RhsWidth-1:0]   rhs;
   logic                  hit;
   logic                  emit;

   assign take_ready = !rsp_valid_ff || rsp_ch.ready;

   // (wa + wb) * 256 <= threshold * wc with wc nonzero, threshold in 8.8
   assign weight_sum = {1'b0, pair.ref_sum} + {1'b0, pair.cmp_sum};
   assign lhs        = {weight_sum, 8'd0};
   assign rhs        = RhsWidth'(threshold) * RhsWidth'(pair.and_sum);
   assign hit        = (pair.and_sum != '0) && (RhsWidth'(lhs) <= rhs);
   assign emit       = pair_valid && take_ready && hit;

   assign rsp_valid_in = take_ready ? (pair_valid && hit) : rsp_valid_ff;
   assign count_in     = (emit && (count_ff != '1)) ? count_ff + CountWidth'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         ref_index_ff <= pair.ref_index;
         cmp_index_ff <= pair.cmp_index;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.match_ref_index = ref_index_ff;
   assign rsp_ch.match_cmp_index = cmp_index_ff;
   assign rsp_ch.match_count     = count_ff;

endmodule

FILE: rtl/tanimoto_pair_screen.sv
`timescale 1ns / 1ps
// path: closing word -> input, popcount, pair and result registers -> rsp_ch
// throughput: one word pair per cycle; ready drops only when every stage is full and the
//   result register is held by rsp_ch.ready
// reset: synchronous, active high; clears accumulators, word position, match count,
//   all stage valids, and sets the ratio threshold to 3.0 (768)
module tanimoto_pair_screen #(
   parameter int FP_WORDS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   tps_req_if.sink                         req_ch,
   tps_rsp_if.source                       rsp_ch,
   input  logic                            csr_write_en,
   input  logic [tps_pkg::ThreshWidth-1:0] csr_write_data
);
   import tps_pkg::*;

   // ratio threshold, unsigned 8.8
   logic [ThreshWidth-1:0] threshold_ff, threshold_in;

   // stage handoff
   logic            weight_valid;
   word_weight_type weight;
   logic            accum_ready;
   logic            pair_valid;
   pair_total_type  pair;
   logic            judge_ready;

   assign threshold_in = csr_write_en ? csr_write_data : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= ThreshReset;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   // input register, then popcounts of ref, cmp and their and
   tps_weigh u_weigh (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .down_ready   (accum_ready),
      .weight_valid (weight_valid),
      .weight       (weight)
   );

   // running weight sums, pair close on last_word or word count
   tps_accum #(
      .FP_WORDS (FP_WORDS)
   ) u_accum (
      .clock        (clock),
      .reset        (reset),
      .weight_valid (weight_valid),
      .weight       (weight),
      .take_ready   (accum_ready),
      .down_ready   (judge_ready),
      .pair_valid   (pair_valid),
      .pair         (pair)
   );

   // ratio compare, match counter and result register
   tps_judge u_judge (
      .clock      (clock),
      .reset      (reset),
      .threshold  (threshold_ff),
      .pair_valid (pair_valid),
      .pair       (pair),
      .take_ready (judge_ready),
      .rsp_ch     (rsp_ch)
   );

   // input stalls only behind a held result with every stage full
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (rsp_ch.valid && !rsp_ch.ready && pair_valid && weight_valid))
      else $error("input stalled without output back pressure");

   // every result carries a nonzero match count
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.match_count != '0))
      else $error("result with zero match count");

   // next result after a taken one counts up, unless saturated
   a_count_advance: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready) ##1 rsp_ch.valid |->
         (rsp_ch.match_count != $past(rsp_ch.match_count)) ||
         ($past(rsp_ch.match_count) == '1))
      else $error("match count did not advance between results");

endmodule

FILE: tb/sv/tanimoto_pair_screen_test.sv
`timescale 1ns / 1ps

module tanimoto_pair_screen_test;
   import tps_pkg::*;

   // words per fingerprint pair, as the block is built by default
   localparam int FpWords      = 32;
   // longer than the pipeline is deep, so this covers a closing word that makes no match
   localparam int SettleCycles = 8;
   localparam int CycleLimit   = 400000;
   localparam int PhaseWords   = 160;
   localparam int IdxMax       = (1 << IdxWidth) - 1;

   // one word pair as it goes onto the request channel
   typedef struct {
      logic [WordWidth-1:0] ref_word;
      logic [WordWidth-1:0] cmp_word;
      logic                 last_word;
      logic [IdxWidth-1:0]  ref_index;
      logic [IdxWidth-1:0]  cmp_index;
   } word_pair_type;

   // one reported match
   typedef struct {
      logic [IdxWidth-1:0]   ref_index;
      logic [IdxWidth-1:0]   cmp_index;
      logic [CountWidth-1:0] count;
   } match_type;

   logic clock;
   logic reset;
   logic                   csr_write_en;
   logic [ThreshWidth-1:0] csr_write_data;

   tps_req_if req_ch ();
   tps_rsp_if rsp_ch ();

   tanimoto_pair_screen #(
      .FP_WORDS(FpWords)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data)
   );

   // word pairs waiting for the driver, matches waiting for the monitor
   word_pair_type word_queue[$];
   match_type     match_queue[$];
   word_pair_type shown;

   // screening state as the block should hold it
   logic [ThreshWidth-1:0] threshold;
   logic [SumWidth-1:0]    ref_total;
   logic [SumWidth-1:0]    cmp_total;
   logic [SumWidth-1:0]    and_total;
   logic [5:0]             word_pos;
   logic [CountWidth-1:0]  match_total;

   int send_idle_pct;
   int recv_stall_pct;
   int errors;
   int cycle_count;
   int words_taken;
   int pairs_closed;
   int matches_checked;
   int settings_used;

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run aborts if the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[tanimoto_pair_screen] ERROR");
         $finish;
      end
   end

   // add popcount to an 11-bit weight sum, clamping at the top
   function automatic logic [SumWidth-1:0] clamp_add(input logic [SumWidth-1:0] sum,
                                                     input int pop);
      int s;
      s = int'(sum) + pop;
      return (s > 2047) ? 11'd2047 : s[SumWidth-1:0];
   endfunction

   // fold one accepted word pair into the pair weights; on close, decide the match
   function automatic void screen_word(input word_pair_type w);
      logic      closing;
      longint    lhs;
      longint    rhs;
      match_type m;
      ref_total = clamp_add(ref_total, $countones(w.ref_word));
      cmp_total = clamp_add(cmp_total, $countones(w.cmp_word));
      and_total = clamp_add(and_total, $countones(w.ref_word & w.cmp_word));
      closing = w.last_word || (int'(word_pos) + 1 >= FpWords);
      if (!closing) begin
         word_pos = word_pos + 6'd1;
         return;
      end
      pairs_closed++;
      // ratio test without division: (ref + cmp) * 256 <= threshold * and
      lhs = (longint'(ref_total) + longint'(cmp_total)) * 256;
      rhs = longint'(threshold) * longint'(and_total);
      if (and_total != '0 && lhs <= rhs) begin
         if (match_total != '1) begin
            match_total = match_total + 1;
         end
         m.ref_index = w.ref_index;
         m.cmp_index = w.cmp_index;
         m.count     = match_total;
         match_queue.push_back(m);
      end
      ref_total = '0;
      cmp_total = '0;
      and_total = '0;
      word_pos  = '0;
   endfunction

   // driver: presents the next queued word pair, holds it until taken
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            screen_word(shown);
            words_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (word_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               shown = word_queue.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.ref_word  <= shown.ref_word;
               req_ch.cmp_word  <= shown.cmp_word;
               req_ch.last_word <= shown.last_word;
               req_ch.ref_index <= shown.ref_index;
               req_ch.cmp_index <= shown.cmp_index;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random back-pressure, each taken match checked against the oldest expected
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (match_queue.size() == 0) begin
               $display("%0t unexpected match ref %h cmp %h count %0d", $time,
                        rsp_ch.match_ref_index, rsp_ch.match_cmp_index, rsp_ch.match_count);
               errors++;
            end else begin
               match_type m;
               m = match_queue.pop_front();
               matches_checked++;
               if (rsp_ch.match_ref_index !== m.ref_index) begin
                  $display("%0t match_ref_index expected %h actual %h", $time,
                           m.ref_index, rsp_ch.match_ref_index);
                  errors++;
               end
               if (rsp_ch.match_cmp_index !== m.cmp_index) begin
                  $display("%0t match_cmp_index expected %h actual %h", $time,
                           m.cmp_index, rsp_ch.match_cmp_index);
                  errors++;
               end
               if (rsp_ch.match_count !== m.count) begin
                  $display("%0t match_count expected %0d actual %0d", $time,
                           m.count, rsp_ch.match_count);
                  errors++;
               end
            end
         end
      end
   end

   task automatic queue_word(input logic [WordWidth-1:0] rw, input logic [WordWidth-1:0] cw,
                             input logic last, input logic [IdxWidth-1:0] ri,
                             input logic [IdxWidth-1:0] ci);
      word_pair_type w;
      w.ref_word  = rw;
      w.cmp_word  = cw;
      w.last_word = last;
      w.ref_index = ri;
      w.cmp_index = ci;
      word_queue.push_back(w);
   endtask

   // one fingerprint pair of the given length and bit style
   //   0: compare is the reference with a few bits flipped, so it often matches
   //   1: unrelated words
   //   2: all ones on both sides, each sum reaches 1024 on a full-depth pair
   //   3: sparse reference, compare a superset of it
   task automatic add_pair(input int words, input int style);
      logic [WordWidth-1:0] rw;
      logic [WordWidth-1:0] cw;
      logic [IdxWidth-1:0]  ri;
      logic [IdxWidth-1:0]  ci;
      logic                 last;
      ri = IdxWidth'($urandom_range(IdxMax));
      ci = IdxWidth'($urandom_range(IdxMax));
      for (int k = 0; k < words; k++) begin
         case (style)
            0: begin
               rw = $urandom;
               cw = rw ^ ($urandom & $urandom & $urandom);
            end
            1: begin
               rw = $urandom;
               cw = $urandom;
            end
            2: begin
               rw = '1;
               cw = '1;
            end
            default: begin
               rw = $urandom & $urandom;
               cw = rw | ($urandom & $urandom & $urandom);
            end
         endcase
         // indices may change inside a pair; the closing word's indices count
         if ($urandom_range(9) == 0) begin
            ri = IdxWidth'($urandom_range(IdxMax));
            ci = IdxWidth'($urandom_range(IdxMax));
         end
         // a full-depth pair closes on its own, with or without the last flag
         last = (k == words - 1) && (words < FpWords || $urandom_range(1) == 1);
         queue_word(rw, cw, last, ri, ci);
      end
   endtask

   // wait for every word taken and every match seen, then let the pipeline empty
   task automatic drain();
      while (word_queue.size() != 0 || req_ch.valid || match_queue.size() != 0) begin
         @(negedge clock);
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [ThreshWidth-1:0] value);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      threshold = value;
      settings_used++;
   endtask

   initial begin
      logic [ThreshWidth-1:0] phase_threshold;
      int                     start_words;
      int                     len;
      int                     kind;

      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      req_ch.valid     = 1'b0;
      req_ch.ref_word  = '0;
      req_ch.cmp_word  = '0;
      req_ch.last_word = 1'b0;
      req_ch.ref_index = '0;
      req_ch.cmp_index = '0;
      rsp_ch.ready     = 1'b0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      errors          = 0;
      cycle_count     = 0;
      words_taken     = 0;
      pairs_closed    = 0;
      matches_checked = 0;
      settings_used   = 1;
      threshold   = ThreshReset;
      ref_total   = '0;
      cmp_total   = '0;
      and_total   = '0;
      word_pos    = '0;
      match_total = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed pairs under the reset threshold of 3.0
      // empty and: nothing in common never matches
      queue_word('0, '0, 1'b1, '0, '0);
      queue_word('1, '0, 1'b1, 20'h00001, 20'h00002);
      queue_word('0, '1, 1'b1, 20'h80000, 20'h40000);
      // identical full words, largest indices
      queue_word('1, '1, 1'b1, 20'hfffff, 20'hfffff);
      // ratio exactly 3.0 matches, just above it does not
      queue_word('1, 32'h0000ffff, 1'b1, 20'h12345, 20'h54321);
      queue_word('1, 32'h00007fff, 1'b1, 20'h0f0f0, 20'hf0f0f);
      // two-word pair with the indices changing on the closing word
      queue_word(32'haaaaaaaa, 32'haaaaaaaa, 1'b0, 20'h00010, 20'h00020);
      queue_word(32'h55555555, 32'h55555555, 1'b1, 20'haaaaa, 20'h55555);
      // three-word pair, single shared bits and partial overlap
      queue_word(32'h80000000, 32'h80000000, 1'b0, 20'h00100, 20'h00200);
      queue_word(32'h00000001, 32'h00000003, 1'b0, 20'h00100, 20'h00200);
      queue_word(32'hffff0000, 32'h0f0f0000, 1'b1, 20'h00100, 20'h00200);
      // disjoint words on a multi-word pair stay unmatched
      queue_word(32'hf0f0f0f0, 32'h0f0f0f0f, 1'b0, 20'h00300, 20'h00400);
      queue_word(32'hcccccccc, 32'h33333333, 1'b1, 20'h00300, 20'h00400);
      drain();

      // random phases: threshold sweep crossed with the four idle patterns
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: phase_threshold = 16'd768;
            1: phase_threshold = 16'd0;
            2: phase_threshold = 16'hffff;
            3: phase_threshold = 16'd512;
            4: phase_threshold = ThreshWidth'($urandom_range(1100, 520));
            5: phase_threshold = 16'd1024;
            6: phase_threshold = ThreshWidth'($urandom_range(65535));
            default: phase_threshold = 16'd640;
         endcase
         write_threshold(phase_threshold);
         @(negedge clock);
         case (phase % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 78;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 78;
            end
            default: begin
               send_idle_pct  = 27;
               recv_stall_pct = 27;
            end
         endcase
         start_words = word_queue.size();
         while (word_queue.size() - start_words < PhaseWords) begin
            kind = $urandom_range(99);
            if (kind < 10) begin
               // stray word with random close flag
               queue_word($urandom, $urandom, 1'($urandom_range(1)),
                          IdxWidth'($urandom_range(IdxMax)),
                          IdxWidth'($urandom_range(IdxMax)));
            end else if (kind < 14) begin
               add_pair(FpWords, ($urandom_range(1) == 1) ? 2 : $urandom_range(3));
            end else begin
               len = $urandom_range(6, 1);
               add_pair(len, (kind < 60) ? 0 : $urandom_range(3));
            end
         end
         // leave no pair open across a threshold change
         queue_word($urandom, $urandom, 1'b1, IdxWidth'($urandom_range(IdxMax)),
                    IdxWidth'($urandom_range(IdxMax)));
         drain();
      end

      $display("screened %0d word pairs closing %0d fingerprint pairs under %0d thresholds",
               words_taken, pairs_closed, settings_used);
      $display("%0d matches compared across free-flow, sender-idle, receiver-stall and mixed",
               matches_checked);
      if (errors == 0) begin
         $display("[tanimoto_pair_screen] OK");
      end else begin
         $display("[tanimoto_pair_screen] ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/tps_pkg.sv
rtl/tps_req_if.sv
rtl/tps_rsp_if.sv
rtl/tps_weigh.sv
rtl/tps_accum.sv
rtl/tps_judge.sv
rtl/tanimoto_pair_screen.sv
tb/sv/tanimoto_pair_screen_test.sv
